// ----- sv/knn_pkg.sv -----
package knn_pkg;

    localparam int NUM_CLASSES   = 16;
    localparam int MAX_INSTANCES = 4096;
    localparam int MAX_K         = 64;

    localparam int CLASS_W = 4;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 38;
    localparam int DIST_W  = 32;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_MODE  = 1'b1;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [SUM_W-1:0]   sum;
    } vote_t;

endpackage

// ----- sv/knn_class_vote_top.sv -----
// Nearest-neighbor class vote. Load the label table with operation 0 (busy stays low). Each
// neighbor (operation 1) reads its label and updates the vote memory; a weighted neighbor at
// nonzero distance first runs the bit-serial divider forming 2^48 / D^2 for its weight. The
// k-th neighbor adds a walk over the 16 class entries of the vote memory, after which done
// pulses for one cycle with the result. Results
// cannot be held off; they must be taken in the cycle done is high.
module knn_class_vote_top
    import knn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [INDEX_W-1:0] neighbour_index,
    input  logic [CLASS_W-1:0] label_value,
    input  logic [DIST_W-1:0]  distance,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data,
    output logic               done,
    output logic [CLASS_W-1:0] predicted_class,
    output logic               from_exact_matches
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LAB  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_WALK = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]          state_reg;
    logic [COUNT_W-1:0]  k_reg;
    logic                mode_reg;
    logic [COUNT_W-1:0]  seen_reg;
    logic                exact_reg;
    logic [NUM_CLASSES-1:0] touched_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [CLASS_W-1:0]  label_reg;
    logic [63:0]         sq_reg;
    logic [64:0]         rem_reg;
    logic [31:0]         quo_reg;
    logic [4:0]          bit_cnt_reg;
    logic [4:0]          walk_reg;
    logic [CLASS_W-1:0]  best_reg;
    logic [SUM_W-1:0]    best_score_reg;
    logic                found_reg;
    logic                done_reg;
    logic [CLASS_W-1:0]  class_reg;
    logic                from_exact_reg;

    logic [CLASS_W-1:0]  label_mem [MAX_INSTANCES];
    logic [CLASS_W-1:0]  lab_rdata_reg;
    vote_t               vote_mem [NUM_CLASSES];
    vote_t               vote_rdata_reg;

    logic                accept;
    logic [COUNT_W-1:0]  k_eff;
    logic [64:0]         trial;
    logic                fits;
    logic [31:0]         weight;
    vote_t               cur;
    vote_t               upd;
    logic                vote_we;
    logic                vote_re;
    logic [CLASS_W-1:0]  vote_addr;
    logic                exact_mode;
    logic [CLASS_W-1:0]  walk_class;
    logic                walk_valid;
    logic [SUM_W-1:0]    score;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign predicted_class    = class_reg;
    assign from_exact_matches = from_exact_reg;

    always_comb
    begin
        if (k_reg == '0)
            k_eff = COUNT_W'(1);
        else if (k_reg > COUNT_W'(MAX_K))
            k_eff = COUNT_W'(MAX_K);
        else
            k_eff = k_reg;
    end

    // restoring divide step of 2^48 by the squared distance
    assign trial = {rem_reg[63:0], 1'b0};
    assign fits  = (trial >= {1'b0, sq_reg});
    assign weight = (sq_reg <= 64'd65536) ? 32'hFFFF_FFFF : quo_reg;

    always_comb
    begin
        cur = touched_reg[label_reg] ? vote_rdata_reg : '0;
        upd = cur;
        if (mode_reg && dist_reg != '0)
            upd.sum = cur.sum + SUM_W'(weight);
        else
            upd.count = cur.count + COUNT_W'(1);
    end

    assign exact_mode = mode_reg && exact_reg;
    assign walk_class = CLASS_W'(walk_reg - 5'd1);
    assign walk_valid = (state_reg == S_WALK) && (walk_reg != 5'd0);

    always_comb
    begin
        vote_re   = (state_reg == S_LAB) ||
                    ((state_reg == S_WALK) && (walk_reg < 5'(NUM_CLASSES)));
        vote_addr = (state_reg == S_LAB) ? lab_rdata_reg : walk_reg[CLASS_W-1:0];
        vote_we   = (state_reg == S_UPD);
        if (!mode_reg || exact_mode)
            score = SUM_W'(vote_rdata_reg.count);
        else
            score = vote_rdata_reg.sum;
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_LOAD)
            label_mem[neighbour_index] <= label_value;
        if (accept)
            lab_rdata_reg <= label_mem[neighbour_index];
        if (vote_we)
            vote_mem[label_reg] <= upd;
        if (vote_re)
            vote_rdata_reg <= vote_mem[vote_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            k_reg          <= COUNT_W'(1);
            mode_reg       <= 1'b0;
            seen_reg       <= '0;
            exact_reg      <= 1'b0;
            touched_reg    <= '0;
            done_reg       <= 1'b0;
            walk_reg       <= '0;
            bit_cnt_reg    <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_COUNT: k_reg    <= cfg_data;
                    CFG_MODE:  mode_reg <= cfg_data[0];
                    default:   k_reg    <= k_reg;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && operation == OP_NEIGHBOR)
                    begin
                        dist_reg  <= distance;
                        state_reg <= S_LAB;
                    end
                end
                S_LAB:
                begin
                    label_reg   <= lab_rdata_reg;
                    sq_reg      <= 64'(dist_reg) * 64'(dist_reg);
                    rem_reg     <= 65'h1_0000;
                    quo_reg     <= '0;
                    bit_cnt_reg <= 5'd31;
                    if (mode_reg && dist_reg != '0)
                        state_reg <= S_DIV;
                    else
                        state_reg <= S_UPD;
                end
                S_DIV:
                begin
                    rem_reg     <= fits ? (trial - {1'b0, sq_reg}) : trial;
                    quo_reg     <= {quo_reg[30:0], fits};
                    bit_cnt_reg <= bit_cnt_reg - 5'd1;
                    if (bit_cnt_reg == 5'd0)
                        state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    touched_reg[label_reg] <= 1'b1;
                    if (mode_reg && dist_reg == '0)
                        exact_reg <= 1'b1;
                    if (seen_reg + COUNT_W'(1) < k_eff)
                    begin
                        seen_reg  <= seen_reg + COUNT_W'(1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        walk_reg  <= '0;
                        found_reg <= 1'b0;
                        best_reg  <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    walk_reg <= walk_reg + 5'd1;
                    if (walk_valid && touched_reg[walk_class] &&
                        ((mode_reg && !exact_mode) || vote_rdata_reg.count != '0) &&
                        (!found_reg || score > best_score_reg))
                    begin
                        found_reg      <= 1'b1;
                        best_reg       <= walk_class;
                        best_score_reg <= score;
                    end
                    if (walk_reg == 5'(NUM_CLASSES))
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    done_reg       <= 1'b1;
                    class_reg      <= best_reg;
                    from_exact_reg <= exact_mode;
                    seen_reg       <= '0;
                    exact_reg      <= 1'b0;
                    touched_reg    <= '0;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/knn_checker.sv -----
module knn_checker
    import knn_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               operation,
    input logic               done
);

    // a result comes only at the end of a busy stretch
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy)) else $error("done outside end of query");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_LOAD) |=> !busy && !done)
        else $error("label transfer made block busy");

    a_nb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_NEIGHBOR) |=> busy)
        else $error("neighbor transfer not started");

endmodule

bind knn_class_vote_top knn_checker u_knn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done)
);
